>>> design/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the COBS frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // Code byte that restores no delimiter before the next code.
    localparam logic [7:0] CODE_NO_RESTORE = 8'd255;

    // Result kinds.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_DELIMITER     = 1'b0;
    localparam logic [0:0] CFG_MAX_FRAME_LEN = 1'b1;

    localparam logic [7:0]  DELIMITER_RESET     = 8'd0;
    localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'hFFFF;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One result item as it travels through the queue.
    typedef struct packed {
        logic [15:0] frame_length;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
    } cfd_item_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } cfd_q_status_t;

endpackage

>>> design/cfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_front
// Accepts received bytes, tracks the frame state and classifies each byte.
// ----------------------------------------------------------------------------
module cfd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_addr,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,      // in_byte [7:0]
    input  cfd_pkg::cfd_q_status_t q_status,
    output logic                 push,
    output cfd_pkg::cfd_item_t   push_item
);

    logic [7:0]  delimiter_reg;
    logic [15:0] max_frame_len_reg;
    logic        in_frame_reg, in_frame_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic [7:0]  next_code_reg, next_code_next;
    logic [15:0] decoded_count_reg, decoded_count_next;
    logic        hit;
    logic        is_delim;

    assign s_tready = !q_status.full;
    assign hit      = s_tvalid && s_tready;
    assign is_delim = (s_tdata == delimiter_reg);

    always_comb begin
        in_frame_next      = in_frame_reg;
        run_count_next     = run_count_reg;
        next_code_next     = next_code_reg;
        decoded_count_next = decoded_count_reg;
        push               = 1'b0;
        push_item          = '{frame_length: 16'd0, kind: cfd_pkg::KIND_DATA,
                               data_byte: 8'd0};
        if (hit) begin
            if (!in_frame_reg) begin
                if (is_delim) begin
                    in_frame_next      = 1'b1;
                    run_count_next     = cfd_pkg::CODE_NO_RESTORE;
                    next_code_next     = cfd_pkg::CODE_NO_RESTORE;
                    decoded_count_next = 16'd0;
                end
            end else if (decoded_count_reg >= max_frame_len_reg) begin
                // The limit is checked before the byte is looked at.
                in_frame_next          = 1'b0;
                push                   = 1'b1;
                push_item.kind         = cfd_pkg::KIND_OVERFLOW;
                push_item.frame_length = decoded_count_reg;
            end else if (is_delim) begin
                in_frame_next          = 1'b0;
                push                   = 1'b1;
                push_item.kind         = cfd_pkg::KIND_END;
                push_item.frame_length = decoded_count_reg;
            end else if (run_count_reg == next_code_reg) begin
                next_code_next = s_tdata;
                run_count_next = 8'd1;
                if (next_code_reg != cfd_pkg::CODE_NO_RESTORE) begin
                    decoded_count_next  = decoded_count_reg + 16'd1;
                    push                = 1'b1;
                    push_item.data_byte = delimiter_reg;
                end
            end else begin
                decoded_count_next  = decoded_count_reg + 16'd1;
                if (run_count_reg != 8'd255) begin
                    run_count_next = run_count_reg + 8'd1;
                end
                push                = 1'b1;
                push_item.data_byte = s_tdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg     <= cfd_pkg::DELIMITER_RESET;
            max_frame_len_reg <= cfd_pkg::MAX_FRAME_LEN_RESET;
            in_frame_reg      <= 1'b0;
            run_count_reg     <= cfd_pkg::CODE_NO_RESTORE;
            next_code_reg     <= cfd_pkg::CODE_NO_RESTORE;
            decoded_count_reg <= 16'd0;
        end else begin
            in_frame_reg      <= in_frame_next;
            run_count_reg     <= run_count_next;
            next_code_reg     <= next_code_next;
            decoded_count_reg <= decoded_count_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    cfd_pkg::CFG_DELIMITER: begin
                        delimiter_reg <= cfg_wr_data[7:0];
                    end
                    cfd_pkg::CFG_MAX_FRAME_LEN: begin
                        max_frame_len_reg <= cfg_wr_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> design/cfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_queue
// Short register queue of result items between the front and the back.
// ----------------------------------------------------------------------------
module cfd_queue #(
    parameter int DEPTH = cfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cfd_pkg::cfd_item_t     push_item,
    input  logic                   pop,
    output cfd_pkg::cfd_item_t     pop_item,
    output cfd_pkg::cfd_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfd_pkg::cfd_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    // A push into a full queue would lose a result item.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full |-> !push)
        else $error("push into full queue");

    // A push without pop raises the count by one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");

endmodule

>>> design/cfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_back
// Drains the queue into the output register and drives the result stream.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfd_pkg::cfd_q_status_t q_status,
    input  cfd_pkg::cfd_item_t     pop_item,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // out_byte [7:0], frame_length [23:8]
    output logic [1:0]             m_tuser    // out_kind [1:0]
);

    logic               valid_reg, valid_next;
    cfd_pkg::cfd_item_t item_reg;

    assign pop        = !q_status.empty && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= pop_item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {item_reg.frame_length, item_reg.data_byte};
    assign m_tuser  = item_reg.kind;

    // A data item carries no length, and a frame ending carries no byte.
    a_field_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ((item_reg.kind == cfd_pkg::KIND_DATA) ?
                       (item_reg.frame_length == 16'd0) : (item_reg.data_byte == 8'd0)))
        else $error("result fields do not match kind");

    // Only the three defined kinds leave the block.
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (item_reg.kind == cfd_pkg::KIND_DATA ||
                       item_reg.kind == cfd_pkg::KIND_END ||
                       item_reg.kind == cfd_pkg::KIND_OVERFLOW))
        else $error("undefined result kind");

endmodule

>>> design/cobs_frame_decoder_unit.sv
`timescale 1ns / 1ps
// A result item is written into the queue at the edge that accepts the byte causing it, then
// moves from the queue into the output register, which drives it on the master side.
// Throughput: one byte per cycle; the front takes a byte whenever the queue has room.
// Reset (aresetn low, synchronous): hunting for a delimiter, queue and output empty,
// delimiter 0 and frame limit 65535.
// ----------------------------------------------------------------------------
// cobs_frame_decoder_unit
// Streaming COBS frame decoder, one received byte per transaction.
// ----------------------------------------------------------------------------
module cobs_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = cfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: index 0 is the delimiter, index 1 the frame length limit.
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    // Received bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte [7:0]
    // Decoded results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte [7:0], frame_length [23:8]
    output logic [1:0]  m_tuser    // out_kind [1:0]
);

    // The front keeps the frame state and decides, for every accepted
    // transaction, whether it produces a result and which one. Results go
    // into a short queue, so the front keeps accepting bytes while the back
    // waits on a stalled master side.
    cfd_pkg::cfd_q_status_t q_status;
    cfd_pkg::cfd_item_t     push_item;
    cfd_pkg::cfd_item_t     pop_item;
    logic                   push;
    logic                   pop;

    cfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    // The queue is sized so that a full-rate stream passes without bubbles.
    cfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // The back moves one queued result into the output register whenever
    // that register is empty or its transaction completes in this cycle.
    cfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_item (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
